/* rtl/tgr_pkg.sv */
// Shared constants for the tone generator: defaults, polynomial coefficients, codes.
`default_nettype none

package tgr_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int INDEX_BITS_DEF      = 24;
    localparam int RAMP_CAP_DEF        = 100;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [15:0] VOLUME_RESET = 16'h8000;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;
    localparam logic [2:0] WAVE_TONE     = 3'd5;

    localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
    localparam logic [1:0] REG_WAVEFORM      = 2'd1;
    localparam logic [1:0] REG_VOLUME        = 2'd2;
    localparam logic [1:0] REG_TOTAL_SAMPLES = 2'd3;

endpackage

`default_nettype wire

/* rtl/tone_generator_with_ramps.sv */
// Top level of the tone generator: waveform, envelope and gain through a serial datapath.
`default_nettype none

// One input beat is one sample tick and yields one output beat. A tick past the
// end of the tone skips the datapath and goes straight to the output. A playing
// tick runs through the single 1-bit-per-cycle shift-add multiplier (ramp
// length, then the sine polynomial for sine or tone, then volume and envelope
// numerator) and the 1-bit-per-cycle restoring divider for the envelope
// denominator. The next beat is taken while a result waits on the output
// side.
module tone_generator_with_ramps #(
    parameter int SINE_TABLE_BITS = tgr_pkg::SINE_TABLE_BITS_DEF,
    parameter int INDEX_BITS      = tgr_pkg::INDEX_BITS_DEF,
    parameter int RAMP_CAP        = tgr_pkg::RAMP_CAP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample_out
    output logic        m_tlast,
    output logic        m_tuser,    // [0] active
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NUM_W   = $clog2(RAMP_CAP + 1);
    localparam int DIV_W   = NUM_W + 17;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int RDIV_W  = $clog2(10 * RAMP_CAP);
    localparam int RDIV_SH = RDIV_W + 4;
    localparam longint unsigned RDIV_KL = ((64'd1 << RDIV_SH) + 64'd9) / 64'd10;
    localparam logic [31:0] RDIV_K = 32'(RDIV_KL);
    localparam logic [INDEX_BITS-1:0] RAMP_FULL_N = INDEX_BITS'(10 * RAMP_CAP);
    localparam logic [NUM_W-1:0] RAMP_CAP_V = NUM_W'(RAMP_CAP);
    localparam int ZSH = 17 - SINE_TABLE_BITS;
    localparam logic [14:0] Z_MASK = 15'({32{1'b1}} << ZSH);
    localparam int CMP_W = (INDEX_BITS > 24) ? INDEX_BITS : 24;
    localparam logic [CMP_W-1:0] IDX_MAX = CMP_W'((64'd1 << INDEX_BITS) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_RAMP,
        OP_Z2,
        OP_T,
        OP_U,
        OP_S,
        OP_VOL,
        OP_NUM
    } op_t;

    logic [31:0]           phase_step_reg;
    logic [2:0]            waveform_reg;
    logic [15:0]           volume_reg;
    logic [23:0]           total_reg;

    logic [INDEX_BITS-1:0] index_reg;
    logic [31:0]           phase_reg;
    logic [15:0]           lfsr_reg;

    state_t                state_reg;
    op_t                   op_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [47:0]           mul_reg;
    logic [31:0]           mcand_reg;
    logic [15:0]           z_reg;
    logic [15:0]           z2_reg;
    logic [15:0]           t_reg;
    logic [15:0]           u_reg;
    logic [15:0]           mag_reg;
    logic                  neg_reg;
    logic                  sine_reg;
    logic [INDEX_BITS-1:0] i_reg;
    logic [INDEX_BITS-1:0] n_reg;
    logic [NUM_W-1:0]      ramp_reg;
    logic [NUM_W-1:0]      den_reg;
    logic [DIV_W-1:0]      dvd_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [16:0]           quo_reg;
    logic                  last_reg;
    logic                  active_reg;

    logic                  m_tvalid_reg;
    logic [15:0]           m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    logic [CMP_W-1:0]      n_ext;
    logic [INDEX_BITS-1:0] n_cur;
    logic [INDEX_BITS-1:0] start_i;
    logic [31:0]           start_p;
    logic                  start_idle;
    logic [15:0]           lfsr_step;
    logic [15:0]           saw_h;
    logic [15:0]           saw_mag;
    logic [17:0]           tri_w;
    logic [15:0]           tri_mag;
    logic [15:0]           noise_w;
    logic [15:0]           noise_mag;
    logic [14:0]           z_raw;
    logic [15:0]           z_start;
    logic [15:0]           mag_start;
    logic                  neg_start;
    logic                  sine_start;

    logic [32:0]           mul_add;
    logic [32:0]           mul_sum;
    logic [47:0]           mul_next;
    logic [15:0]           prod_q15;
    logic [NUM_W-1:0]      ramp_div10;

    logic [INDEX_BITS-1:0] ramp_ext;
    logic [NUM_W-1:0]      num_sel;
    logic [NUM_W-1:0]      den_sel;
    logic [31:0]           ld_mcand;
    logic [15:0]           ld_mplier;

    logic [NUM_W:0]        div_trial;
    logic                  div_ge;
    logic [NUM_W-1:0]      div_rem_next;

    logic [15:0]           sat_pos;
    logic [15:0]           sat_neg;
    logic [15:0]           sample_sel;
    logic                  out_load;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    assign n_ext      = CMP_W'(total_reg);
    assign n_cur      = (n_ext > IDX_MAX) ? IDX_MAX[INDEX_BITS-1:0] : n_ext[INDEX_BITS-1:0];
    assign start_i    = s_tdata[0] ? '0 : index_reg;
    assign start_p    = s_tdata[0] ? '0 : phase_reg;
    assign start_idle = (start_i >= n_cur);

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ tgr_pkg::LFSR_MASK) : (lfsr_reg >> 1);

    assign saw_h     = start_p[31:16];
    assign saw_mag   = saw_h[15] ? (~saw_h + 16'd1) : saw_h;
    assign tri_w     = {1'b0, saw_mag, 1'b0} - 18'd32768;
    assign tri_mag   = tri_w[17] ? 16'(~tri_w + 18'd1) : tri_w[15:0];
    assign noise_w   = {~lfsr_step[15], lfsr_step[14:0]};
    assign noise_mag = noise_w[15] ? (~noise_w + 16'd1) : noise_w;
    assign z_raw     = start_p[29:15] & Z_MASK;
    assign z_start   = start_p[30] ? 16'(17'd32768 - {2'b00, z_raw}) : {1'b0, z_raw};

    always_comb
    begin
        mag_start  = '0;
        neg_start  = 1'b0;
        sine_start = 1'b0;
        unique case (waveform_reg) inside
            tgr_pkg::WAVE_SINE, tgr_pkg::WAVE_TONE:
            begin
                neg_start  = start_p[31];
                sine_start = 1'b1;
            end
            tgr_pkg::WAVE_SQUARE:
            begin
                mag_start = 16'h8000;
                neg_start = start_p[31];
            end
            tgr_pkg::WAVE_SAW:
            begin
                mag_start = saw_mag;
                neg_start = saw_h[15];
            end
            tgr_pkg::WAVE_TRIANGLE:
            begin
                mag_start = tri_mag;
                neg_start = tri_w[17];
            end
            tgr_pkg::WAVE_NOISE:
            begin
                mag_start = noise_mag;
                neg_start = noise_w[15];
            end
            default:
            begin
                mag_start = '0;
            end
        endcase
    end

    assign mul_add    = mul_reg[0] ? {1'b0, mcand_reg} : 33'd0;
    assign mul_sum    = {1'b0, mul_reg[47:16]} + mul_add;
    assign mul_next   = {mul_sum, mul_reg[15:1]};
    assign prod_q15   = mul_next[30:15];
    assign ramp_div10 = mul_next[RDIV_SH +: NUM_W];

    assign ramp_ext = INDEX_BITS'(ramp_reg);

    always_comb
    begin
        num_sel = NUM_W'(1);
        den_sel = NUM_W'(1);
        if (i_reg < ramp_ext)
        begin
            num_sel = i_reg[NUM_W-1:0];
            den_sel = ramp_reg;
        end
        else if ((ramp_reg != '0) && (i_reg > n_reg - ramp_ext))
        begin
            num_sel = NUM_W'(n_reg - i_reg);
            den_sel = ramp_reg;
        end
    end

    always_comb
    begin
        ld_mcand  = '0;
        ld_mplier = '0;
        unique case (op_reg)
            OP_RAMP:
            begin
                ld_mcand  = RDIV_K;
                ld_mplier = n_reg[15:0];
            end
            OP_Z2:
            begin
                ld_mcand  = {16'd0, z_reg};
                ld_mplier = z_reg;
            end
            OP_T:
            begin
                ld_mcand  = {16'd0, z2_reg};
                ld_mplier = tgr_pkg::SIN_C;
            end
            OP_U:
            begin
                ld_mcand  = {16'd0, z2_reg};
                ld_mplier = t_reg;
            end
            OP_S:
            begin
                ld_mcand  = {16'd0, z_reg};
                ld_mplier = u_reg;
            end
            OP_VOL:
            begin
                ld_mcand  = {16'd0, mag_reg};
                ld_mplier = volume_reg;
            end
            OP_NUM:
            begin
                ld_mcand  = mul_reg[31:0];
                ld_mplier = 16'(num_sel);
            end
            default:
            begin
                ld_mcand  = '0;
            end
        endcase
    end

    assign div_trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge       = (div_trial >= {1'b0, den_reg});
    assign div_rem_next = div_ge ? NUM_W'(div_trial - {1'b0, den_reg})
                                 : div_trial[NUM_W-1:0];

    assign sat_pos    = (quo_reg > 17'd32767) ? 16'h7FFF : quo_reg[15:0];
    assign sat_neg    = (quo_reg > 17'd32768) ? 16'h8000 : (~quo_reg[15:0] + 16'd1);
    assign sample_sel = neg_reg ? sat_neg : sat_pos;

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            waveform_reg   <= tgr_pkg::WAVE_SINE;
            volume_reg     <= tgr_pkg::VOLUME_RESET;
            total_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tgr_pkg::REG_PHASE_STEP:    phase_step_reg <= cfg_data;
                tgr_pkg::REG_WAVEFORM:      waveform_reg   <= cfg_data[2:0];
                tgr_pkg::REG_VOLUME:        volume_reg     <= cfg_data[15:0];
                tgr_pkg::REG_TOTAL_SAMPLES: total_reg      <= cfg_data[23:0];
                default:                    total_reg      <= total_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            phase_reg    <= '0;
            lfsr_reg     <= tgr_pkg::LFSR_SEED;
            state_reg    <= S_IDLE;
            op_reg       <= OP_RAMP;
            cnt_reg      <= '0;
            mul_reg      <= '0;
            mcand_reg    <= '0;
            z_reg        <= '0;
            z2_reg       <= '0;
            t_reg        <= '0;
            u_reg        <= '0;
            mag_reg      <= '0;
            neg_reg      <= 1'b0;
            sine_reg     <= 1'b0;
            i_reg        <= '0;
            n_reg        <= '0;
            ramp_reg     <= '0;
            den_reg      <= NUM_W'(1);
            dvd_reg      <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            last_reg     <= 1'b0;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        i_reg    <= start_i;
                        n_reg    <= n_cur;
                        z_reg    <= z_start;
                        mag_reg  <= mag_start;
                        sine_reg <= sine_start;
                        if (start_idle)
                        begin
                            index_reg  <= start_i;
                            phase_reg  <= start_p;
                            neg_reg    <= 1'b0;
                            quo_reg    <= '0;
                            last_reg   <= 1'b0;
                            active_reg <= 1'b0;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            index_reg  <= start_i + INDEX_BITS'(1);
                            phase_reg  <= start_p + phase_step_reg;
                            if (waveform_reg == tgr_pkg::WAVE_NOISE)
                            begin
                                lfsr_reg <= lfsr_step;
                            end
                            neg_reg    <= neg_start;
                            last_reg   <= (start_i == n_cur - INDEX_BITS'(1));
                            active_reg <= 1'b1;
                            op_reg     <= OP_RAMP;
                            state_reg  <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    mcand_reg <= ld_mcand;
                    mul_reg   <= {32'd0, ld_mplier};
                    cnt_reg   <= '0;
                    if (op_reg == OP_NUM)
                    begin
                        den_reg <= den_sel;
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    mul_reg <= mul_next;
                    if (cnt_reg != CNT_W'(15))
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (op_reg == OP_NUM) ? S_DIV : S_LOAD;
                        unique case (op_reg)
                            OP_RAMP:
                            begin
                                ramp_reg <= (n_reg >= RAMP_FULL_N) ? RAMP_CAP_V : ramp_div10;
                                op_reg   <= sine_reg ? OP_Z2 : OP_VOL;
                            end
                            OP_Z2:
                            begin
                                z2_reg <= prod_q15;
                                op_reg <= OP_T;
                            end
                            OP_T:
                            begin
                                t_reg  <= tgr_pkg::SIN_B - prod_q15;
                                op_reg <= OP_U;
                            end
                            OP_U:
                            begin
                                u_reg  <= tgr_pkg::SIN_A - prod_q15;
                                op_reg <= OP_S;
                            end
                            OP_S:
                            begin
                                mag_reg <= prod_q15;
                                op_reg  <= OP_VOL;
                            end
                            OP_VOL:
                            begin
                                op_reg <= OP_NUM;
                            end
                            OP_NUM:
                            begin
                                dvd_reg <= mul_next[15 +: DIV_W];
                                rem_reg <= '0;
                                quo_reg <= '0;
                            end
                            default:
                            begin
                                op_reg <= OP_RAMP;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_rem_next;
                    quo_reg <= {quo_reg[15:0], div_ge};
                    dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_W - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= sample_sel;
                        m_tlast_reg  <= last_reg;
                        m_tuser_reg  <= active_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    idle_beat_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata == 16'd0) && !m_tlast))
        else $error("idle beat carries a nonzero sample or last flag");

    last_beat_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last flag on an inactive beat");

    divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("envelope divisor is zero");

    envelope_ratio_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOAD) && (op_reg == OP_NUM)) |-> (num_sel <= den_sel))
        else $error("envelope numerator exceeds denominator");

    idle_tick_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tdata[0] && (index_reg >= n_cur))
        |=> ($stable(index_reg) && $stable(phase_reg)))
        else $error("tick past the end of the tone moved the index or phase");
`endif

endmodule

`default_nettype wire
